### design/atilt_pkg.sv
// Shared types and constants for the accelerometer tilt-angle core.
`default_nettype none
package atilt_pkg;

	typedef struct packed {
		logic signed [31:0] accel_x;
		logic signed [31:0] accel_y;
		logic signed [31:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic signed [23:0] tilt_x;
		logic signed [23:0] tilt_y;
		logic signed [23:0] tilt_z;
	} tilt_t;

	localparam int unsigned CORDIC_ITERS = 28;
	localparam int unsigned SQRT_STEPS   = 32;
	localparam int unsigned ANGLE_FRAC   = 24;
	localparam int unsigned OUT_FRAC     = 16;
	localparam int unsigned HALF_TURN    = 180;
	localparam int unsigned RIGHT_DEG    = HALF_TURN / 2;
	localparam logic signed [31:0] RIGHT_Q24 = 32'(RIGHT_DEG << ANGLE_FRAC);
	localparam logic signed [23:0] RIGHT_Q16 = 24'(RIGHT_DEG << OUT_FRAC);

	// atan(2^-i) in degrees, 24 fraction bits
	function automatic logic signed [31:0] atan_q24(input int unsigned i);
		logic signed [31:0] t;
		unique case (i)
			0: t = 32'sd754974720;
			1: t = 32'sd445687602;
			2: t = 32'sd235489088;
			3: t = 32'sd119537938;
			4: t = 32'sd60000934;
			5: t = 32'sd30029717;
			6: t = 32'sd15018523;
			7: t = 32'sd7509720;
			8: t = 32'sd3754917;
			9: t = 32'sd1877466;
			10: t = 32'sd938734;
			11: t = 32'sd469367;
			12: t = 32'sd234684;
			13: t = 32'sd117342;
			14: t = 32'sd58671;
			15: t = 32'sd29335;
			16: t = 32'sd14668;
			17: t = 32'sd7334;
			18: t = 32'sd3667;
			19: t = 32'sd1833;
			20: t = 32'sd917;
			21: t = 32'sd458;
			22: t = 32'sd229;
			23: t = 32'sd115;
			24: t = 32'sd57;
			25: t = 32'sd29;
			26: t = 32'sd14;
			27: t = 32'sd7;
			default: t = 32'sd0;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

### design/atilt_norm.sv
// Front stage: axis magnitudes, signs and common left shift to full scale.
`default_nettype none
module atilt_norm (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire atilt_pkg::sample_t sample,
	output logic [31:0]             mag_x_s1,
	output logic [31:0]             mag_y_s1,
	output logic [31:0]             mag_z_s1,
	output logic [2:0]              neg_s1
);

	logic [31:0] mx, my, mz, m;
	logic [4:0]  sh;

	always_comb begin
		mx = sample.accel_x[31] ? 32'(-sample.accel_x) : 32'(sample.accel_x);
		my = sample.accel_y[31] ? 32'(-sample.accel_y) : 32'(sample.accel_y);
		mz = sample.accel_z[31] ? 32'(-sample.accel_z) : 32'(sample.accel_z);
		m  = mx | my | mz;
		// smallest shift that lifts the top bit to 30 or 31
		sh = 5'd0;
		for (int b = 0; b < 30; b++) begin
			if (m[b]) begin
				sh = 5'(30 - b);
			end
		end
		// already at full scale
		if (m[31:30] != 2'b00) begin
			sh = 5'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_x_s1 <= mx << sh;
			mag_y_s1 <= my << sh;
			mag_z_s1 <= mz << sh;
			neg_s1   <= {sample.accel_z[31], sample.accel_y[31], sample.accel_x[31]};
		end
	end

endmodule
`default_nettype wire

### design/atilt_lane.sv
// One angle lane: squares, pipelined integer square root, pipelined CORDIC, rounding.
`default_nettype none
module atilt_lane (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] own,
	input  wire logic        neg,
	input  wire logic [31:0] p,
	input  wire logic [31:0] q,
	output logic [23:0]      tilt_q
);

	localparam int unsigned NS = atilt_pkg::SQRT_STEPS;
	localparam int unsigned NC = atilt_pkg::CORDIC_ITERS;

	logic [63:0] sq_p_s1, sq_q_s1;
	logic [31:0] own_s1;
	logic        neg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_p_s1 <= 64'(p) * 64'(p);
			sq_q_s1 <= 64'(q) * 64'(q);
			own_s1  <= own;
			neg_s1  <= neg;
		end
	end

	// square-root pipeline, one result bit per stage
	logic [63:0] rn  [0:NS];
	logic [63:0] rr  [0:NS];
	logic [31:0] ro  [0:NS];
	logic        rng [0:NS];

	always_ff @(posedge clk) begin
		if (en) begin
			rn[0]  <= sq_p_s1 + sq_q_s1;
			rr[0]  <= 64'd0;
			ro[0]  <= own_s1;
			rng[0] <= neg_s1;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		assign trial = rr[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rn[k] >= trial) begin
					rn[k+1] <= rn[k] - trial;
					rr[k+1] <= (rr[k] >> 1) + BIT;
				end else begin
					rn[k+1] <= rn[k];
					rr[k+1] <= rr[k] >> 1;
				end
				ro[k+1]  <= ro[k];
				rng[k+1] <= rng[k];
			end
		end
	end

	// vectoring CORDIC
	logic signed [63:0] cx [0:NC];
	logic signed [63:0] cy [0:NC];
	logic signed [31:0] cz [0:NC];
	logic               c_own0 [0:NC];
	logic               c_r0   [0:NC];
	logic               c_neg  [0:NC];

	always_ff @(posedge clk) begin
		if (en) begin
			cx[0]     <= {4'd0, rr[NS][31:0], 28'd0};
			cy[0]     <= {4'd0, ro[NS], 28'd0};
			cz[0]     <= 32'sd0;
			c_own0[0] <= (ro[NS] == 32'd0);
			c_r0[0]   <= (rr[NS][31:0] == 32'd0);
			c_neg[0]  <= rng[NS];
		end
	end

	for (genvar i = 0; i < NC; i++) begin : g_cordic
		localparam logic signed [31:0] T = atilt_pkg::atan_q24(i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy[i][63]) begin
					cx[i+1] <= cx[i] + (cy[i] >>> i);
					cy[i+1] <= cy[i] - (cx[i] >>> i);
					cz[i+1] <= cz[i] + T;
				end else begin
					cx[i+1] <= cx[i] - (cy[i] >>> i);
					cy[i+1] <= cy[i] + (cx[i] >>> i);
					cz[i+1] <= cz[i] - T;
				end
				c_own0[i+1] <= c_own0[i];
				c_r0[i+1]   <= c_r0[i];
				c_neg[i+1]  <= c_neg[i];
			end
		end
	end

	logic signed [31:0] zc;
	logic signed [23:0] mag, res;

	always_comb begin
		if (cz[NC] < 32'sd0) begin
			zc = 32'sd0;
		end else if (cz[NC] > atilt_pkg::RIGHT_Q24) begin
			zc = atilt_pkg::RIGHT_Q24;
		end else begin
			zc = cz[NC];
		end
		mag = 24'((zc + 32'sd128) >>> 8);
		if (c_own0[NC]) begin
			res = 24'sd0;
		end else if (c_r0[NC]) begin
			res = c_neg[NC] ? -atilt_pkg::RIGHT_Q16 : atilt_pkg::RIGHT_Q16;
		end else begin
			res = c_neg[NC] ? -mag : mag;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tilt_q <= res;
		end
	end

endmodule
`default_nettype wire

### design/accel_tilt_angles_core.sv
// Throughput: one sample per cycle while no finished result is stalled; the
// 32-step square root and 28-step CORDIC pipelines in each of the three
// lanes set the depth.
// The whole pipeline holds while a finished result is stalled.
// Reset clears only the valid bits; data registers are not reset.
`default_nettype none
module accel_tilt_angles_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sample_valid,
	output logic                    sample_stall,
	input  wire atilt_pkg::sample_t sample,
	output logic                    tilt_valid,
	input  wire logic               tilt_stall,
	output atilt_pkg::tilt_t        tilt
);

	localparam int unsigned DEPTH = 2 + 1 + 1 + atilt_pkg::SQRT_STEPS + 1
		+ atilt_pkg::CORDIC_ITERS + 1;

	logic             en;
	logic [DEPTH-1:0] vld_q;
	logic [31:0]      mx, my, mz;
	logic [2:0]       neg;
	logic [23:0]      lx, ly, lz;

	assign en           = !(vld_q[DEPTH-1] && tilt_stall);
	assign sample_stall = !en;
	assign tilt_valid   = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], sample_valid};
		end
	end

	atilt_norm u_norm (
		.clk      (clk),
		.en       (en),
		.sample   (sample),
		.mag_x_s1 (mx),
		.mag_y_s1 (my),
		.mag_z_s1 (mz),
		.neg_s1   (neg)
	);

	atilt_lane u_lane_x (.clk(clk), .en(en), .own(mx), .neg(neg[0]), .p(my), .q(mz), .tilt_q(lx));
	atilt_lane u_lane_y (.clk(clk), .en(en), .own(my), .neg(neg[1]), .p(mx), .q(mz), .tilt_q(ly));
	atilt_lane u_lane_z (.clk(clk), .en(en), .own(mz), .neg(neg[2]), .p(mx), .q(my), .tilt_q(lz));

	// merge lanes into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			tilt.tilt_x <= lx;
			tilt.tilt_y <= ly;
			tilt.tilt_z <= lz;
		end
	end

endmodule
`default_nettype wire
